[sv/urtb_pkg.sv]
// ----------------------------------------------------------------------------
// urtb_pkg: serial port receive / transmit ring buffers, shared definitions
// ring depths, derived widths, item kind codes and the near-full level reset
// ----------------------------------------------------------------------------
package urtb_pkg;

    typedef logic [7:0] t_byte;

    localparam int RX_DEPTH         = 256;
    localparam int TX_DEPTH         = 256;
    localparam int NEAR_FULL_MARGIN = 64;

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int TX_FW = $clog2(TX_DEPTH + 1);
    // compare width for the fill count against the 8 bit level
    localparam int RX_CW = (RX_AW > 8) ? RX_AW : 8;

    localparam int RX_LEVEL_RST_I = ((RX_DEPTH - NEAR_FULL_MARGIN) > 255) ? 255 :
                                    (((RX_DEPTH - NEAR_FULL_MARGIN) < 0) ? 0 :
                                     (RX_DEPTH - NEAR_FULL_MARGIN));
    localparam t_byte RX_LEVEL_RST  = t_byte'(RX_LEVEL_RST_I);

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_IRQ  = 2'd0;
    localparam t_kind KIND_READ = 2'd1;
    localparam t_kind KIND_SEND = 2'd2;
    localparam t_kind KIND_NOP  = 2'd3;

endpackage

[sv/uart_rx_tx_ring_buffers.sv]
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers: receive and transmit rings for a serial port
// interrupt events, host reads and host sends update two byte rings
// ----------------------------------------------------------------------------
// usage
// - command channel: an item is taken at a rising edge with start high and
//   busy low; i_kind selects interrupt event, host read, host send or no-op
// - result channel: o_done is high for exactly one cycle, the cycle after the
//   item was taken, and all o_ result ports are valid in that cycle; the
//   receiver cannot stall, so nothing is ever held back
// - throughput is one item per clock while busy is low: the pointer update,
//   fill compare and one ring write/read of each ring fit between the input
//   edge and the ram read register, so start may stay high every cycle
// - the results are registered behind the registered read of the ring rams
// - config channel: one register (rx near-full level) written on
//   i_cfg_valid & o_cfg_ready; ready is always high, write only while idle
// - reset (synchronous, active low) clears all pointers and flags and loads
//   the near-full level; after release a clearing pass zeroes the receive
//   ring, one entry per cycle, and busy stays high until it finishes;
//   config transactions are taken during the pass
// ----------------------------------------------------------------------------
module uart_rx_tx_ring_buffers
    import urtb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    // command channel
    input  logic  start,
    output logic  busy,
    input  t_kind i_kind,
    input  logic  i_idle_seen,
    input  logic  i_line_error,
    input  logic  i_rx_valid,
    input  t_byte i_rx_byte,
    input  logic  i_tx_empty,
    input  t_byte i_send_byte,
    input  logic  i_send_first,
    input  logic  i_send_last,
    // config channel
    input  logic  i_cfg_valid,
    output logic  o_cfg_ready,
    input  t_byte i_cfg_data,
    // result channel
    output logic  o_done,
    output logic  o_notify_idle,
    output logic  o_notify_nearly_full,
    output logic  o_tx_valid,
    output t_byte o_tx_byte,
    output t_byte o_read_byte,
    output t_byte o_rx_count,
    output logic  o_send_status,
    output logic  o_tx_overflow,
    output logic  o_rx_overflow,
    output logic  o_tx_running
);

    // ring pointer helpers, wrap without a divider
    function automatic logic [RX_AW-1:0] rx_inc(input logic [RX_AW-1:0] p);
        return (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [TX_AW-1:0] tx_inc(input logic [TX_AW-1:0] p);
        return (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [RX_AW-1:0] rx_fill(input logic [RX_AW-1:0] w,
                                                 input logic [RX_AW-1:0] r);
        logic [RX_AW:0] sum;
        sum = {1'b0, w} + ((w >= r) ? (RX_AW+1)'(0) : (RX_AW+1)'(RX_DEPTH))
              - {1'b0, r};
        return sum[RX_AW-1:0];
    endfunction

    // receive ring state
    logic [RX_AW-1:0] r_rx_wr, n_rx_wr;
    logic [RX_AW-1:0] r_rx_rd, n_rx_rd;
    logic             r_rx_ovf, n_rx_ovf;
    t_byte            r_level;

    // transmit ring state
    logic [TX_AW-1:0] r_tx_wr, n_tx_wr;
    logic [TX_AW-1:0] r_tx_rd, n_tx_rd;
    logic [TX_FW-1:0] r_tx_fill, n_tx_fill;
    logic             r_tx_busy, n_tx_busy;
    logic             r_tx_ovf, n_tx_ovf;
    logic             r_tx_drop, n_tx_drop;

    // receive ring clearing pass after reset
    logic             r_clr_active;
    logic [RX_AW-1:0] r_clr_addr;

    // result stage
    logic  r_done;
    logic  r_notify_idle, n_notify_idle;
    logic  r_notify_full;
    logic  r_tx_pop;
    logic  r_tx_bypass;
    t_byte r_bypass_byte;
    logic  r_rd_pop;
    logic  r_send_status, n_send_status;

    // per item control
    logic             accept;
    logic             full_chk;
    logic             tx_pop;
    logic             tx_bypass;
    logic             rd_pop;
    logic             rx_item_we;
    logic [RX_AW-1:0] rx_item_addr;
    logic [RX_AW-1:0] rx_wr_inc;
    logic             tx_we;
    logic [TX_FW-1:0] tx_fill_inc;
    logic [RX_AW-1:0] rx_fill_nxt;
    logic [RX_AW-1:0] rx_fill_cur;
    logic             notify_full;

    // ram ports
    logic             rx_we;
    logic [RX_AW-1:0] rx_waddr;
    t_byte            rx_wdata;
    t_byte            rx_q;
    t_byte            tx_q;

    assign accept      = start & ~busy;
    assign busy        = r_clr_active;
    assign o_cfg_ready = 1'b1;

    // write pointer seen by a byte store: after a possible error flush
    assign rx_wr_inc   = rx_inc(i_line_error ? '0 : r_rx_wr);
    assign tx_fill_inc = r_tx_fill + 1'b1;

    // ------------------------------------------------------------------------
    // next state for one item, interrupt handled in order:
    // idle notify, error flush, byte store, transmit feed
    // ------------------------------------------------------------------------
    always_comb begin
        n_rx_wr       = r_rx_wr;
        n_rx_rd       = r_rx_rd;
        n_rx_ovf      = r_rx_ovf;
        n_tx_wr       = r_tx_wr;
        n_tx_rd       = r_tx_rd;
        n_tx_fill     = r_tx_fill;
        n_tx_busy     = r_tx_busy;
        n_tx_ovf      = r_tx_ovf;
        n_tx_drop     = r_tx_drop;
        n_notify_idle = 1'b0;
        n_send_status = 1'b0;
        full_chk      = 1'b0;
        tx_pop        = 1'b0;
        tx_bypass     = 1'b0;
        rd_pop        = 1'b0;
        rx_item_we    = 1'b0;
        rx_item_addr  = r_rx_wr;
        tx_we         = 1'b0;

        if (accept) begin
            case (i_kind)
                KIND_IRQ: begin
                    n_notify_idle = i_idle_seen;
                    if (i_line_error) begin
                        n_rx_wr = '0;
                        n_rx_rd = '0;
                    end
                    if (i_rx_valid) begin
                        rx_item_we   = 1'b1;
                        rx_item_addr = n_rx_wr;
                        full_chk     = 1'b1;
                        // write meets read: overflow, ring emptied
                        if (rx_wr_inc == n_rx_rd) begin
                            n_rx_wr  = '0;
                            n_rx_rd  = '0;
                            n_rx_ovf = 1'b1;
                        end else begin
                            n_rx_wr = rx_wr_inc;
                        end
                    end
                    // ready interrupt only matters while running
                    if (i_tx_empty && r_tx_busy) begin
                        if (r_tx_fill != '0) begin
                            tx_pop    = 1'b1;
                            n_tx_rd   = tx_inc(r_tx_rd);
                            n_tx_fill = r_tx_fill - 1'b1;
                        end else begin
                            n_tx_busy = 1'b0;
                        end
                    end
                end
                KIND_READ: begin
                    // unguarded pop, wraps when empty
                    rd_pop  = 1'b1;
                    n_rx_rd = rx_inc(r_rx_rd);
                end
                KIND_SEND: begin
                    if (i_send_first) begin
                        n_tx_ovf  = 1'b0;
                        n_tx_drop = 1'b0;
                    end
                    if (!n_tx_drop) begin
                        tx_we   = 1'b1;
                        n_tx_wr = tx_inc(r_tx_wr);
                        if (tx_fill_inc == TX_FW'(TX_DEPTH)) begin
                            // ring full: flush and drop the rest of the call
                            n_tx_ovf  = 1'b1;
                            n_tx_drop = 1'b1;
                            n_tx_wr   = '0;
                            n_tx_rd   = '0;
                            n_tx_fill = '0;
                        end else if (i_send_last && !r_tx_busy) begin
                            // kick the transmitter with the head byte
                            tx_pop    = 1'b1;
                            tx_bypass = (r_tx_rd == r_tx_wr);
                            n_tx_rd   = tx_inc(r_tx_rd);
                            n_tx_fill = r_tx_fill;
                            n_tx_busy = 1'b1;
                        end else begin
                            n_tx_fill = tx_fill_inc;
                        end
                    end
                    if (i_send_last) begin
                        n_tx_drop = 1'b0;
                    end
                    n_send_status = n_tx_ovf;
                end
                default: begin
                end
            endcase
        end
    end

    assign rx_fill_nxt = rx_fill(n_rx_wr, n_rx_rd);
    assign rx_fill_cur = rx_fill(r_rx_wr, r_rx_rd);
    assign notify_full = full_chk & (RX_CW'(rx_fill_nxt) == RX_CW'(r_level));

    // clearing pass owns the receive write port while busy
    assign rx_we    = r_clr_active | rx_item_we;
    assign rx_waddr = r_clr_active ? r_clr_addr : rx_item_addr;
    assign rx_wdata = r_clr_active ? '0 : i_rx_byte;

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_wr       <= '0;
            r_rx_rd       <= '0;
            r_rx_ovf      <= 1'b0;
            r_level       <= RX_LEVEL_RST;
            r_tx_wr       <= '0;
            r_tx_rd       <= '0;
            r_tx_fill     <= '0;
            r_tx_busy     <= 1'b0;
            r_tx_ovf      <= 1'b0;
            r_tx_drop     <= 1'b0;
            r_clr_active  <= 1'b1;
            r_clr_addr    <= '0;
            r_done        <= 1'b0;
            r_notify_idle <= 1'b0;
            r_notify_full <= 1'b0;
            r_tx_pop      <= 1'b0;
            r_tx_bypass   <= 1'b0;
            r_rd_pop      <= 1'b0;
            r_send_status <= 1'b0;
        end else begin
            r_rx_wr       <= n_rx_wr;
            r_rx_rd       <= n_rx_rd;
            r_rx_ovf      <= n_rx_ovf;
            r_tx_wr       <= n_tx_wr;
            r_tx_rd       <= n_tx_rd;
            r_tx_fill     <= n_tx_fill;
            r_tx_busy     <= n_tx_busy;
            r_tx_ovf      <= n_tx_ovf;
            r_tx_drop     <= n_tx_drop;
            if (i_cfg_valid && o_cfg_ready) begin
                r_level <= i_cfg_data;
            end
            if (r_clr_active) begin
                r_clr_addr <= rx_inc(r_clr_addr);
                if (r_clr_addr == RX_AW'(RX_DEPTH - 1)) begin
                    r_clr_active <= 1'b0;
                end
            end
            r_done        <= accept;
            r_notify_idle <= n_notify_idle;
            r_notify_full <= notify_full;
            r_tx_pop      <= tx_pop;
            r_tx_bypass   <= tx_bypass;
            r_rd_pop      <= rd_pop;
            r_send_status <= n_send_status;
        end
    end

    // byte written in the same cycle as a kick from an empty ring
    always_ff @(posedge i_clk) begin
        r_bypass_byte <= i_send_byte;
    end

    // ------------------------------------------------------------------------
    // ring memories
    // ------------------------------------------------------------------------
    urtb_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (rx_waddr),
        .i_wdata (rx_wdata),
        .i_raddr (r_rx_rd),
        .o_rdata (rx_q)
    );

    urtb_ram #(
        .WIDTH (8),
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (r_tx_wr),
        .i_wdata (i_send_byte),
        .i_raddr (r_tx_rd),
        .o_rdata (tx_q)
    );

    // ------------------------------------------------------------------------
    // result ports: state registers already hold the post-item values
    // ------------------------------------------------------------------------
    assign o_done               = r_done;
    assign o_notify_idle        = r_notify_idle;
    assign o_notify_nearly_full = r_notify_full;
    assign o_tx_valid           = r_tx_pop;
    assign o_tx_byte            = r_tx_pop ? (r_tx_bypass ? r_bypass_byte : tx_q) : '0;
    assign o_read_byte          = r_rd_pop ? rx_q : '0;
    assign o_rx_count           = t_byte'(RX_CW'(rx_fill_cur));
    assign o_send_status        = r_send_status;
    assign o_tx_overflow        = r_tx_ovf;
    assign o_rx_overflow        = r_rx_ovf;
    assign o_tx_running         = r_tx_busy;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_done_follows_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("result strobe missing after an accepted item");

    a_tx_valid_running : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_tx_valid) |-> o_tx_running)
        else $error("byte handed out while transmitter not running");

    a_tx_fill_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_fill < TX_FW'(TX_DEPTH))
        else $error("transmit fill reached ring depth");

    a_drop_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_drop |-> (r_tx_fill == '0))
        else $error("transmit ring holds bytes while dropping");

    a_clear_once : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_clr_active |=> !r_clr_active)
        else $error("clearing pass restarted without reset");

endmodule

[sv/urtb_ram.sv]
// ----------------------------------------------------------------------------
// urtb_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module urtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[tb/tb_uart_rx_tx_ring_buffers.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_rx_tx_ring_buffers: self-checking bench for the serial port rings
// interrupt events, host reads and host sends go in through the command
// handshake; a scoreboard class mirrors both rings and the flags and checks
// every result transaction; the near-full level is reprogrammed between phases
// ----------------------------------------------------------------------------
module tb_uart_rx_tx_ring_buffers;
    import urtb_pkg::*;

    // one command transaction, every field as on the ports
    typedef struct {
        t_kind kind;
        logic  idle_seen;
        logic  line_error;
        logic  rx_valid;
        t_byte rx_byte;
        logic  tx_empty;
        t_byte send_byte;
        logic  send_first;
        logic  send_last;
    } t_ring_cmd;

    // what the result strobe carries
    typedef struct {
        logic  notify_idle;
        logic  notify_nearly_full;
        logic  tx_valid;
        t_byte tx_byte;
        t_byte read_byte;
        t_byte rx_count;
        logic  send_status;
        logic  tx_overflow;
        logic  rx_overflow;
        logic  tx_running;
    } t_ring_outcome;

    // ------------------------------------------------------------------------
    // scoreboard: mirror of both rings, queue of outcomes still to arrive
    // ------------------------------------------------------------------------
    class t_serial_rings;
        t_byte            rx_mem [RX_DEPTH];
        t_byte            tx_mem [TX_DEPTH];
        logic [RX_AW-1:0] rx_wr, rx_rd;
        logic [TX_AW-1:0] tx_wr, tx_rd;
        logic [TX_FW-1:0] tx_fill;
        logic             tx_busy, tx_ovf, rx_ovf, tx_drop;
        t_byte            level;
        t_ring_outcome    outcome_q [$];
        int unsigned      fails;

        function new();
            foreach (rx_mem[i]) rx_mem[i] = '0;
            foreach (tx_mem[i]) tx_mem[i] = '0;
            rx_wr   = '0;
            rx_rd   = '0;
            tx_wr   = '0;
            tx_rd   = '0;
            tx_fill = '0;
            tx_busy = 1'b0;
            tx_ovf  = 1'b0;
            rx_ovf  = 1'b0;
            tx_drop = 1'b0;
            level   = RX_LEVEL_RST;
            fails   = 0;
        endfunction

        function void set_level(t_byte lvl);
            level = lvl;
        endfunction

        function int unsigned pending();
            return outcome_q.size();
        endfunction

        function t_byte tx_pop();
            t_byte b;
            b = tx_mem[tx_rd];
            tx_rd++;
            tx_fill--;
            return b;
        endfunction

        // note an accepted transaction and queue the outcome it must give
        function void take_item(t_ring_cmd c);
            t_ring_outcome o;
            o = '{default: '0};
            case (c.kind)
                KIND_IRQ: begin
                    o.notify_idle = c.idle_seen;
                    if (c.line_error) begin
                        rx_wr = '0;
                        rx_rd = '0;
                    end
                    if (c.rx_valid) begin
                        rx_mem[rx_wr] = c.rx_byte;
                        rx_wr++;
                        if (rx_wr == rx_rd) begin
                            rx_wr  = '0;
                            rx_rd  = '0;
                            rx_ovf = 1'b1;
                        end
                        if (t_byte'(rx_wr - rx_rd) == level)
                            o.notify_nearly_full = 1'b1;
                    end
                    if (c.tx_empty && tx_busy) begin
                        if (tx_fill > 0) begin
                            o.tx_valid = 1'b1;
                            o.tx_byte  = tx_pop();
                        end else begin
                            tx_busy = 1'b0;
                        end
                    end
                end
                KIND_READ: begin
                    o.read_byte = rx_mem[rx_rd];
                    rx_rd++;
                end
                KIND_SEND: begin
                    if (c.send_first) begin
                        tx_ovf  = 1'b0;
                        tx_drop = 1'b0;
                    end
                    if (!tx_drop) begin
                        tx_mem[tx_wr] = c.send_byte;
                        tx_wr++;
                        tx_fill++;
                        if (tx_fill >= TX_DEPTH) begin
                            tx_ovf  = 1'b1;
                            tx_drop = 1'b1;
                            tx_wr   = '0;
                            tx_rd   = '0;
                            tx_fill = '0;
                        end else if (c.send_last && !tx_busy && tx_fill > 0) begin
                            o.tx_valid = 1'b1;
                            o.tx_byte  = tx_pop();
                            tx_busy    = 1'b1;
                        end
                    end
                    if (c.send_last)
                        tx_drop = 1'b0;
                    o.send_status = tx_ovf;
                end
                default: ;
            endcase
            o.rx_count    = t_byte'(rx_wr - rx_rd);
            o.tx_overflow = tx_ovf;
            o.rx_overflow = rx_ovf;
            o.tx_running  = tx_busy;
            outcome_q.push_back(o);
        endfunction

        task report(string msg);
            fails++;
            $display("%0t mismatch: %s", $realtime, msg);
        endtask

        task check_field(string name, t_byte got, t_byte want);
            if (got !== want)
                report($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check_bit(string name, logic got, logic want);
            if (got !== want)
                report($sformatf("%s got %0b want %0b", name, got, want));
        endtask

        task check_result(t_ring_outcome got);
            t_ring_outcome want;
            if (outcome_q.size() == 0) begin
                report("result strobe with no transaction outstanding");
                return;
            end
            want = outcome_q.pop_front();
            check_bit("notify_idle", got.notify_idle, want.notify_idle);
            check_bit("notify_nearly_full", got.notify_nearly_full,
                      want.notify_nearly_full);
            check_bit("tx_valid", got.tx_valid, want.tx_valid);
            check_field("tx_byte", got.tx_byte, want.tx_byte);
            check_field("read_byte", got.read_byte, want.read_byte);
            check_field("rx_count", got.rx_count, want.rx_count);
            check_bit("send_status", got.send_status, want.send_status);
            check_bit("tx_overflow", got.tx_overflow, want.tx_overflow);
            check_bit("rx_overflow", got.rx_overflow, want.rx_overflow);
            check_bit("tx_running", got.tx_running, want.tx_running);
        endtask

        task check_drained();
            if (outcome_q.size() != 0)
                report($sformatf("%0d results never arrived", outcome_q.size()));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic  i_clk        = 1'b0;
    logic  i_rst_n      = 1'b0;
    logic  start        = 1'b0;
    t_kind i_kind       = KIND_NOP;
    logic  i_idle_seen  = 1'b0;
    logic  i_line_error = 1'b0;
    logic  i_rx_valid   = 1'b0;
    t_byte i_rx_byte    = '0;
    logic  i_tx_empty   = 1'b0;
    t_byte i_send_byte  = '0;
    logic  i_send_first = 1'b0;
    logic  i_send_last  = 1'b0;
    logic  i_cfg_valid  = 1'b0;
    t_byte i_cfg_data   = '0;

    logic  busy, o_cfg_ready, o_done;
    logic  o_notify_idle, o_notify_nearly_full, o_tx_valid;
    t_byte o_tx_byte, o_read_byte, o_rx_count;
    logic  o_send_status, o_tx_overflow, o_rx_overflow, o_tx_running;

    t_serial_rings rings = new();
    t_ring_outcome seen;
    int unsigned   items_sent = 0;

    always #5 i_clk = ~i_clk;

    uart_rx_tx_ring_buffers uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_kind               (i_kind),
        .i_idle_seen          (i_idle_seen),
        .i_line_error         (i_line_error),
        .i_rx_valid           (i_rx_valid),
        .i_rx_byte            (i_rx_byte),
        .i_tx_empty           (i_tx_empty),
        .i_send_byte          (i_send_byte),
        .i_send_first         (i_send_first),
        .i_send_last          (i_send_last),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_data           (i_cfg_data),
        .o_done               (o_done),
        .o_notify_idle        (o_notify_idle),
        .o_notify_nearly_full (o_notify_nearly_full),
        .o_tx_valid           (o_tx_valid),
        .o_tx_byte            (o_tx_byte),
        .o_read_byte          (o_read_byte),
        .o_rx_count           (o_rx_count),
        .o_send_status        (o_send_status),
        .o_tx_overflow        (o_tx_overflow),
        .o_rx_overflow        (o_rx_overflow),
        .o_tx_running         (o_tx_running)
    );

    // results cannot be held off, so every strobe is checked at its edge
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            seen.notify_idle        = o_notify_idle;
            seen.notify_nearly_full = o_notify_nearly_full;
            seen.tx_valid           = o_tx_valid;
            seen.tx_byte            = o_tx_byte;
            seen.read_byte          = o_read_byte;
            seen.rx_count           = o_rx_count;
            seen.send_status        = o_send_status;
            seen.tx_overflow        = o_tx_overflow;
            seen.rx_overflow        = o_rx_overflow;
            seen.tx_running         = o_tx_running;
            rings.check_result(seen);
        end
    end

    // ------------------------------------------------------------------------
    // transaction builders: fields the kind ignores are left random
    // ------------------------------------------------------------------------
    function automatic t_ring_cmd random_cmd();
        t_ring_cmd c;
        c.kind       = t_kind'($urandom_range(0, 3));
        c.idle_seen  = 1'($urandom_range(0, 1));
        c.line_error = 1'($urandom_range(0, 1));
        c.rx_valid   = 1'($urandom_range(0, 1));
        c.rx_byte    = t_byte'($urandom);
        c.tx_empty   = 1'($urandom_range(0, 1));
        c.send_byte  = t_byte'($urandom);
        c.send_first = 1'($urandom_range(0, 1));
        c.send_last  = 1'($urandom_range(0, 1));
        return c;
    endfunction

    function automatic t_ring_cmd irq_cmd(logic idle, logic err, logic rxv,
                                          t_byte b, logic txe);
        t_ring_cmd c;
        c            = random_cmd();
        c.kind       = KIND_IRQ;
        c.idle_seen  = idle;
        c.line_error = err;
        c.rx_valid   = rxv;
        c.rx_byte    = b;
        c.tx_empty   = txe;
        return c;
    endfunction

    function automatic t_ring_cmd send_cmd(t_byte b, logic first, logic last);
        t_ring_cmd c;
        c            = random_cmd();
        c.kind       = KIND_SEND;
        c.send_byte  = b;
        c.send_first = first;
        c.send_last  = last;
        return c;
    endfunction

    function automatic t_ring_cmd read_cmd();
        t_ring_cmd c;
        c      = random_cmd();
        c.kind = KIND_READ;
        return c;
    endfunction

    // mostly back to back, some short pauses, the odd long one
    function automatic int unsigned pick_gap(bit quiet);
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 25);
    endfunction

    // ------------------------------------------------------------------------
    // drivers: entered and left at a falling edge
    // ------------------------------------------------------------------------
    task automatic drive_item(input t_ring_cmd c, input int unsigned gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start        <= 1'b1;
        i_kind       <= c.kind;
        i_idle_seen  <= c.idle_seen;
        i_line_error <= c.line_error;
        i_rx_valid   <= c.rx_valid;
        i_rx_byte    <= c.rx_byte;
        i_tx_empty   <= c.tx_empty;
        i_send_byte  <= c.send_byte;
        i_send_first <= c.send_first;
        i_send_last  <= c.send_last;
        // busy is read before the edge updates it
        do @(posedge i_clk); while (busy !== 1'b0);
        rings.take_item(c);
        if (c.kind != KIND_NOP)
            items_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_level(input t_byte lvl);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= lvl;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        rings.set_level(lvl);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // wait until every result is in, then let the result pipeline drain
    task automatic settle();
        int unsigned n;
        n = 0;
        while (rings.pending() != 0 && n < 1000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (3) @(negedge i_clk);
    endtask

    // one random sequence; long_kind forces a long sequence near a ring depth
    // (1: a send call of 254 to 260 bytes against the transmit depth, 2: a
    // receive burst of 250 to 300 bytes against the receive depth)
    task automatic run_sequence(input int unsigned long_kind);
        int unsigned pick, len;
        bit          quiet, no_first, no_last;
        t_ring_cmd   c;
        quiet = ($urandom_range(0, 3) == 0);
        case (long_kind)
            1:       pick = 50;
            2:       pick = 0;
            default: pick = $urandom_range(0, 99);
        endcase
        if (pick < 25) begin
            // receive burst, now and then long enough to wrap the ring
            len = (long_kind == 2 || $urandom_range(0, 79) == 0) ?
                  $urandom_range(250, 300) : $urandom_range(1, 24);
            repeat (len) begin
                c = irq_cmd($urandom_range(0, 7) == 0, $urandom_range(0, 31) == 0,
                            1'b1, t_byte'($urandom), $urandom_range(0, 3) == 0);
                drive_item(c, pick_gap(quiet));
            end
        end else if (pick < 45) begin
            // host reads, often running past empty
            len = $urandom_range(1, 20);
            repeat (len) drive_item(read_cmd(), pick_gap(quiet));
        end else if (pick < 70) begin
            // one send call; a few lack their first or last marker
            len = (long_kind == 1 || $urandom_range(0, 79) == 0) ?
                  $urandom_range(254, 260) : $urandom_range(1, 8);
            no_first = ($urandom_range(0, 9) == 0);
            no_last  = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < len; i++) begin
                c = send_cmd(t_byte'($urandom), i == 0 && !no_first,
                             i == len - 1 && !no_last);
                drive_item(c, pick_gap(quiet));
            end
        end else if (pick < 90) begin
            // transmitter ready interrupts draining the transmit ring
            len = $urandom_range(1, 12);
            repeat (len) begin
                c = irq_cmd($urandom_range(0, 15) == 0, $urandom_range(0, 31) == 0,
                            $urandom_range(0, 3) == 0, t_byte'($urandom), 1'b1);
                drive_item(c, pick_gap(quiet));
            end
        end else begin
            // noise: any kind, any fields
            len = $urandom_range(1, 4);
            repeat (len) drive_item(random_cmd(), pick_gap(quiet));
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        t_byte levels [5];
        levels = '{8'd255, 8'd1, RX_LEVEL_RST, t_byte'($urandom_range(2, 254)), 8'd0};

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // level zero first; the write is taken during the clearing pass
        write_level(8'd0);

        // directed part on a freshly cleared block
        // one transaction of any kind straight after the pass
        drive_item(random_cmd(), 0);
        drive_item(irq_cmd(1'b1, 1'b0, 1'b0, t_byte'($urandom), 1'b0), 0);
        drive_item(irq_cmd(1'b0, 1'b0, 1'b1, 8'hff, 1'b0), pick_gap(1'b0));
        drive_item(irq_cmd(1'b0, 1'b0, 1'b1, 8'h00, 1'b0), 0);
        drive_item(read_cmd(), pick_gap(1'b0));
        drive_item(read_cmd(), 0);
        // third read; on an empty ring the fill wraps to the top
        drive_item(read_cmd(), 0);
        // write meets read: overflow, ring empties, level zero notify
        drive_item(irq_cmd(1'b0, 1'b0, 1'b1, 8'ha5, 1'b0), pick_gap(1'b0));
        // everything at once: idle, error flush, store, ready while stopped
        drive_item(irq_cmd(1'b1, 1'b1, 1'b1, 8'h5a, 1'b1), 0);
        // single byte call starts transmission at once
        drive_item(send_cmd(8'h00, 1'b1, 1'b1), 0);
        drive_item(send_cmd(8'hff, 1'b1, 1'b0), pick_gap(1'b0));
        // last byte while running: queued, no new start
        drive_item(send_cmd(8'h12, 1'b0, 1'b1), 0);
        repeat (3) drive_item(irq_cmd(1'b0, 1'b0, 1'b0, t_byte'($urandom), 1'b1), 0);
        // transmitter ready while stopped is ignored
        drive_item(irq_cmd(1'b0, 1'b0, 1'b0, t_byte'($urandom), 1'b1), pick_gap(1'b0));
        drive_item(send_cmd(8'hc3, 1'b0, 1'b1), 0);
        drive_item(irq_cmd(1'b0, 1'b0, 1'b0, t_byte'($urandom), 1'b1), 0);
        drive_item(read_cmd(), 0);
        drive_item(irq_cmd(1'b0, 1'b1, 1'b0, t_byte'($urandom), 1'b0), 0);

        // random phases, one level setting each, extremes among them;
        // the item budget grows by a hundred per phase
        for (int p = 0; p < 5; p++) begin
            start <= 1'b0;
            settle();
            write_level(levels[p]);
            run_sequence(p == 1 ? 1 : 0);
            while (items_sent < 32'(100 * (p + 1)))
                run_sequence(0);
        end

        start <= 1'b0;
        settle();
        rings.check_drained();
        if (rings.fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // safety net well beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

[sim.f]
sv/urtb_pkg.sv
sv/urtb_ram.sv
sv/uart_rx_tx_ring_buffers.sv
tb/tb_uart_rx_tx_ring_buffers.sv
